/* hw/rtl/strict_priority_call_scheduler_assert.svh */
// Assertion macros used by the checker file.
`ifndef STRICT_PRIORITY_CALL_SCHEDULER_ASSERT_SVH
`define STRICT_PRIORITY_CALL_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define SPS_ASSERT_IMPLY(LABEL, CLK, RSTN, A, C) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |-> (C)) \
		else $error("sps assertion failed");

// Next-cycle implication.
`define SPS_ASSERT_NEXT(LABEL, CLK, RSTN, A, C) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |=> (C)) \
		else $error("sps assertion failed");

`endif

/* hw/rtl/sps_pkg.sv */
package sps_pkg;

	typedef enum logic [1:0] {
		EV_QUEUED    = 2'd0,
		EV_DROPPED   = 2'd1,
		EV_ANSWERED  = 2'd2,
		EV_IDLE_TICK = 2'd3
	} event_t;

	typedef enum logic {
		ST_RUN,
		ST_READ
	} state_t;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = 1;
	localparam int CMDQ_CNT_W = 2;

	typedef struct packed {
		logic        is_tick;
		logic        cls_ok;
		logic [1:0]  caller_class;
		logic [15:0] caller_id;
		logic [15:0] service_time;
	} cmd_t;

	typedef struct packed {
		event_t      event_kind;
		logic [15:0] answered_id;
		logic [1:0]  answered_class;
		logic [31:0] tick_number;
	} res_t;

endpackage

/* hw/rtl/sps_if.sv */
interface sps_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [1:0]  caller_class;
	logic [15:0] caller_id;
	logic [15:0] service_time;

	modport source (output valid, operation, caller_class, caller_id, service_time,
		input ready);
	modport sink (input valid, operation, caller_class, caller_id, service_time,
		output ready);
endinterface

interface sps_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [15:0] answered_id;
	logic [1:0]  answered_class;
	logic [31:0] tick_number;

	modport source (output valid, event_kind, answered_id, answered_class, tick_number,
		input ready);
	modport sink (input valid, event_kind, answered_id, answered_class, tick_number,
		output ready);
endinterface

/* hw/rtl/sps_front.sv */
module sps_front import sps_pkg::*; #(
	parameter int NUM_CLASSES = 4
) (
	sps_in_if.sink in_ch,
	input  logic   q_full,
	output logic   push,
	output cmd_t   cmd
);

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	always_comb begin
		cmd.is_tick      = in_ch.operation;
		cmd.cls_ok       = int'(in_ch.caller_class) < NUM_CLASSES;
		cmd.caller_class = in_ch.caller_class;
		cmd.caller_id    = in_ch.caller_id;
		cmd.service_time = in_ch.service_time;
	end

endmodule

/* hw/rtl/sps_cmd_fifo.sv */
module sps_cmd_fifo import sps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t rd_data
);

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;

	assign full      = cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH);
	assign not_empty = cnt_q != '0;
	assign rd_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CMDQ_CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CMDQ_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_data;
	end

endmodule

/* hw/rtl/sps_back.sv */
module sps_back import sps_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int NUM_CLASSES = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic out_valid,
	input  logic out_ready,
	output res_t res
);

	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int CLS_W     = $clog2(NUM_CLASSES);
	localparam int ADDR_W    = CLS_W + PTR_W;
	localparam int MEM_DEPTH = NUM_CLASSES * (2 ** PTR_W);

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	logic [31:0]       mem_q [MEM_DEPTH];
	logic [31:0]       rd_data_q;
	logic [PTR_W-1:0]  head_q [NUM_CLASSES];
	logic [PTR_W-1:0]  tail_q [NUM_CLASSES];
	logic [CNT_W-1:0]  cnt_q  [NUM_CLASSES];
	logic [15:0]       busy_q;
	logic [31:0]       tick_q;
	logic [CLS_W-1:0]  sel_q;
	state_t            state_q, state_d;
	logic              out_valid_q;
	res_t              res_q;

	logic              out_free;
	logic              any_waiting;
	logic [CLS_W-1:0]  sel;
	logic [CLS_W-1:0]  idx;
	logic              full;
	logic [ADDR_W-1:0] mem_addr;
	logic              start;
	logic              push_q_en, pop_q_en, wr_en, rd_en;
	logic              busy_dec, busy_load, tick_inc, load_res;
	res_t              res_d;
	logic [15:0]       dur;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign dur       = rd_data_q[31:16];

	always_comb begin
		any_waiting = 1'b0;
		sel         = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (cnt_q[c] != '0) begin
				any_waiting = 1'b1;
				sel         = CLS_W'(c);
			end
		end
	end

	assign idx      = cmd.is_tick ? sel : CLS_W'(cmd.caller_class);
	assign full     = cnt_q[idx] == CNT_W'(QUEUE_DEPTH);
	assign mem_addr = {idx, cmd.is_tick ? head_q[idx] : tail_q[idx]};
	assign start    = (state_q == ST_RUN) && cmd_valid && out_free;
	assign cmd_pop  = start;

	always_comb begin
		state_d   = state_q;
		push_q_en = 1'b0;
		pop_q_en  = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		busy_dec  = 1'b0;
		busy_load = 1'b0;
		tick_inc  = 1'b0;
		load_res  = 1'b0;
		res_d     = '{event_kind: EV_IDLE_TICK, answered_id: '0, answered_class: '0,
			tick_number: tick_q};
		unique case (state_q)
			ST_RUN: begin
				if (start) begin
					if (!cmd.is_tick) begin
						load_res             = 1'b1;
						res_d.answered_id    = cmd.caller_id;
						res_d.answered_class = cmd.caller_class;
						if (!cmd.cls_ok || full) begin
							res_d.event_kind = EV_DROPPED;
						end else begin
							res_d.event_kind = EV_QUEUED;
							wr_en            = 1'b1;
							push_q_en        = 1'b1;
						end
					end else if (busy_q != '0 || !any_waiting) begin
						load_res = 1'b1;
						tick_inc = 1'b1;
						busy_dec = busy_q != '0;
					end else begin
						rd_en    = 1'b1;
						pop_q_en = 1'b1;
						state_d  = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (out_free) begin
					load_res             = 1'b1;
					tick_inc             = 1'b1;
					busy_load            = 1'b1;
					res_d.event_kind     = EV_ANSWERED;
					res_d.answered_id    = rd_data_q[15:0];
					res_d.answered_class = 2'(sel_q);
					state_d              = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_RUN;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				tail_q[c] <= '0;
				cnt_q[c]  <= '0;
			end
			busy_q      <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_q_en) begin
				tail_q[idx] <= ring_next(tail_q[idx]);
				cnt_q[idx]  <= cnt_q[idx] + CNT_W'(1);
			end
			if (pop_q_en) begin
				head_q[idx] <= ring_next(head_q[idx]);
				cnt_q[idx]  <= cnt_q[idx] - CNT_W'(1);
			end
			if (busy_dec)
				busy_q <= busy_q - 16'd1;
			else if (busy_load)
				busy_q <= (dur == '0) ? '0 : dur - 16'd1;
			if (tick_inc)
				tick_q <= tick_q + 32'd1;
			if (load_res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res)
			res_q <= res_d;
		if (rd_en)
			sel_q <= idx;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[mem_addr] <= {cmd.service_time, cmd.caller_id};
		if (rd_en)
			rd_data_q <= mem_q[mem_addr];
	end

endmodule

/* hw/rtl/strict_priority_call_scheduler.sv */
// Strict-priority call scheduler: one item in, one result out. Arrivals go to
// their class queue (class 0 highest) or are reported dropped when it is full
// or the class is out of range; each tick counts down the busy server, answers
// the head of the highest non-empty class, or, with the server idle and every
// queue empty, only advances the tick number. Items are decoded into a two-entry
// command queue and executed by the back end one at a time. A tick that answers
// a call passes through the read state after the run state, since the call
// store is a memory with a registered read port; other items end in the run
// state. Sustained rate is one item per cycle while the output is not stalled,
// and no new item is taken in the read state. The call store is not cleared
// after reset; no entry is read before it is written.
module strict_priority_call_scheduler import sps_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int NUM_CLASSES = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	sps_in_if.sink   in_ch,
	sps_out_if.source out_ch
);

	logic q_full, push, q_not_empty, pop;
	cmd_t cmd_in, cmd_out;
	res_t res;

	sps_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push),
		.cmd    (cmd_in)
	);

	sps_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (cmd_in),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.rd_data   (cmd_out)
	);

	sps_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .NUM_CLASSES(NUM_CLASSES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (cmd_out),
		.cmd_pop   (pop),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.res       (res)
	);

	assign out_ch.event_kind     = res.event_kind;
	assign out_ch.answered_id    = res.answered_id;
	assign out_ch.answered_class = res.answered_class;
	assign out_ch.tick_number    = res.tick_number;

endmodule

/* hw/rtl/sps_checker.sv */
`include "strict_priority_call_scheduler_assert.svh"

module sps_checker import sps_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  event_kind,
	input logic [31:0] tick_number
);

	localparam logic [3:0] PEND_MAX = 4'd4;

	logic [3:0]  pending_q;
	logic [31:0] exp_tick_q;
	logic        in_acc, out_acc, is_tick_res;

	assign in_acc      = in_valid && in_ready;
	assign out_acc     = out_valid && out_ready;
	assign is_tick_res = (event_kind == EV_ANSWERED) || (event_kind == EV_IDLE_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			exp_tick_q <= '0;
		end else begin
			if (in_acc && !out_acc)
				pending_q <= pending_q + 4'd1;
			else if (out_acc && !in_acc)
				pending_q <= pending_q - 4'd1;
			if (out_acc)
				exp_tick_q <= tick_number + {31'd0, is_tick_res};
		end
	end

	`SPS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`SPS_ASSERT_IMPLY(a_no_phantom, clk, arst_n, out_valid, pending_q != 4'd0)
	`SPS_ASSERT_IMPLY(a_pending_bound, clk, arst_n, 1'b1, pending_q <= PEND_MAX)
	`SPS_ASSERT_IMPLY(a_tick_seq, clk, arst_n, out_acc, tick_number == exp_tick_q)

endmodule

bind strict_priority_call_scheduler sps_checker u_sps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.event_kind  (out_ch.event_kind),
	.tick_number (out_ch.tick_number)
);
